// ----- hw/rtl/flv_video_tag_deframer_defines.svh -----
// Assertion macros shared by the deframer checker.
// Depends on nothing; include by bare file name.
`ifndef FLV_VIDEO_TAG_DEFRAMER_DEFINES_SVH
`define FLV_VIDEO_TAG_DEFRAMER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define FLVD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define FLVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

`endif

// ----- hw/rtl/flvd_pkg.sv -----
// Types and constants of the FLV video tag deframer.
// No dependencies; used by every module of the block.
package flvd_pkg;

    localparam int HDR_LEN     = 13;
    localparam int TAG_BYTES   = 13;
    localparam int TRAILER_LEN = 4;

    localparam logic [7:0]  SIG_F       = 8'h46;
    localparam logic [7:0]  SIG_L       = 8'h4C;
    localparam logic [7:0]  SIG_V       = 8'h56;
    localparam logic [7:0]  FLV_VERSION = 8'h01;
    localparam logic [31:0] DATA_OFFSET = 32'd9;

    localparam logic [7:0] VIDEO_KIND_RESET = 8'd9;
    localparam logic [3:0] JPEG_CODEC_RESET = 4'd1;

    localparam int        ADDR_W           = 3;
    localparam logic      REG_VIDEO_KIND   = 1'b0;
    localparam logic      REG_JPEG_CODEC   = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_TAG     = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_TRAILER = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_HDR_OK  = 3'd1,
        EV_HDR_BAD = 3'd2,
        EV_TAG_BAD = 3'd3,
        EV_TAG_OK  = 3'd4
    } event_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_last;
        logic [63:0] frame_timestamp;
        logic [2:0]  event_code;
    } out_item_t;

    typedef struct packed {
        logic [7:0] video_tag_kind;
        logic [3:0] jpeg_codec_code;
    } cfg_t;

endpackage

// ----- hw/rtl/flvd_parser.sv -----
// Parser state and per-byte decode of the FLV video tag deframer.
// Depends on flvd_pkg.
module flvd_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  flvd_pkg::in_item_t    item,
    input  flvd_pkg::cfg_t        cfg,
    output flvd_pkg::out_item_t   result
);

    flvd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic             header_good_reg, header_good_next;
    logic [31:0]      offset_reg, offset_next;
    logic [7:0]       kind_reg, kind_next;
    logic [23:0]      remain_reg, remain_next;
    logic [63:0]      ts_reg, ts_next;

    flvd_pkg::phase_t cur_phase;
    logic [3:0]       cur_pos;
    logic             cur_good;
    logic [7:0]       b;
    logic [23:0]      remain_dec;
    logic             tag_ok;

    // Restart drops back to header byte zero before this byte is taken.
    assign b          = item.stream_byte;
    assign cur_phase  = item.restart ? flvd_pkg::PH_HEADER : phase_reg;
    assign cur_pos    = item.restart ? 4'd0 : pos_reg;
    assign cur_good   = item.restart ? 1'b1 : header_good_reg;
    assign remain_dec = remain_reg - 24'd1;
    assign tag_ok     = (kind_reg == cfg.video_tag_kind) && (remain_reg != 24'd0)
                     && (b[3:0] == cfg.jpeg_codec_code);

    always_comb
    begin
        phase_next       = cur_phase;
        pos_next         = cur_pos;
        header_good_next = cur_good;
        offset_next      = offset_reg;
        kind_next        = kind_reg;
        remain_next      = remain_reg;
        ts_next          = ts_reg;
        result           = '0;

        unique case (cur_phase)
            flvd_pkg::PH_HEADER:
            begin
                unique case (cur_pos)
                    4'd0: header_good_next = (b == flvd_pkg::SIG_F);
                    4'd1: header_good_next = cur_good & (b == flvd_pkg::SIG_L);
                    4'd2: header_good_next = cur_good & (b == flvd_pkg::SIG_V);
                    4'd3: header_good_next = cur_good & (b == flvd_pkg::FLV_VERSION);
                    4'd4: header_good_next = cur_good & b[0];
                    4'd5, 4'd6, 4'd7: offset_next = {offset_reg[23:0], b};
                    4'd8:
                    begin
                        offset_next      = {offset_reg[23:0], b};
                        header_good_next = cur_good
                                         & ({offset_reg[23:0], b} == flvd_pkg::DATA_OFFSET);
                    end
                    default: ;
                endcase
                if (cur_pos >= 4'(flvd_pkg::HDR_LEN - 1))
                begin
                    pos_next = 4'd0;
                    if (header_good_next)
                    begin
                        result.event_code = flvd_pkg::EV_HDR_OK;
                        phase_next        = flvd_pkg::PH_TAG;
                    end
                    else
                    begin
                        result.event_code = flvd_pkg::EV_HDR_BAD;
                        header_good_next  = 1'b1;
                    end
                end
                else
                begin
                    pos_next = cur_pos + 4'd1;
                end
            end
            flvd_pkg::PH_TAG:
            begin
                if (cur_pos == 4'd0)
                    kind_next = b;
                else if (cur_pos <= 4'd3)
                    remain_next = {remain_reg[15:0], b};
                else if (cur_pos < 4'(flvd_pkg::TAG_BYTES - 1))
                    ts_next = {ts_reg[55:0], b};

                if (cur_pos >= 4'(flvd_pkg::TAG_BYTES - 1))
                begin
                    pos_next = 4'd0;
                    if (!tag_ok)
                    begin
                        result.event_code = flvd_pkg::EV_TAG_BAD;
                        phase_next        = flvd_pkg::PH_HEADER;
                        header_good_next  = 1'b1;
                    end
                    else
                    begin
                        result.event_code      = flvd_pkg::EV_TAG_OK;
                        result.frame_timestamp = ts_reg;
                        remain_next            = remain_dec;
                        // Size of one means no body: flag the empty frame now.
                        if (remain_dec == 24'd0)
                        begin
                            result.frame_last = 1'b1;
                            phase_next        = flvd_pkg::PH_TRAILER;
                        end
                        else
                        begin
                            phase_next = flvd_pkg::PH_BODY;
                        end
                    end
                end
                else
                begin
                    pos_next = cur_pos + 4'd1;
                end
            end
            flvd_pkg::PH_BODY:
            begin
                result.payload_byte    = b;
                result.payload_valid   = 1'b1;
                result.frame_timestamp = ts_reg;
                if (remain_reg <= 24'd1)
                begin
                    remain_next       = 24'd0;
                    result.frame_last = 1'b1;
                    phase_next        = flvd_pkg::PH_TRAILER;
                    pos_next          = 4'd0;
                end
                else
                begin
                    remain_next = remain_dec;
                end
            end
            flvd_pkg::PH_TRAILER:
            begin
                if (cur_pos >= 4'(flvd_pkg::TRAILER_LEN - 1))
                begin
                    phase_next = flvd_pkg::PH_TAG;
                    pos_next   = 4'd0;
                end
                else
                begin
                    pos_next = cur_pos + 4'd1;
                end
            end
            default:
            begin
                phase_next       = flvd_pkg::PH_HEADER;
                pos_next         = 4'd0;
                header_good_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= flvd_pkg::PH_HEADER;
            pos_reg         <= 4'd0;
            header_good_reg <= 1'b1;
            offset_reg      <= '0;
            kind_reg        <= '0;
            remain_reg      <= '0;
            ts_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            header_good_reg <= header_good_next;
            offset_reg      <= offset_next;
            kind_reg        <= kind_next;
            remain_reg      <= remain_next;
            ts_reg          <= ts_next;
        end
    end

endmodule

// ----- hw/rtl/flv_video_tag_deframer.sv -----
// Top level of the FLV video tag deframer: handshake, input and result registers,
// configuration port. Depends on flvd_pkg and flvd_parser.
//
// The deframer takes one stream byte per item and returns exactly one result item
// per input item, in order. Throughput is one item per clock cycle: an item is
// held in the input register, decoded combinationally by the parser and written
// into the result register, so a new item enters every cycle while the result
// side keeps taking. The parser first checks the 13-byte stream header (event 1
// or 2), then walks tag, body and trailer; a good video/JPEG tag gives event 4,
// a bad one event 3 and a return to header search. Body bytes come out with
// payload_valid, the tag timestamp and frame_last on the final byte; a tag of
// size one gives an empty-frame marker (event 4 with frame_last). Setting restart
// on an item makes that byte header byte zero. Two registers sit on the APB port:
// video tag kind at byte address 0 (reset 9) and JPEG codec code at byte address
// 4 (reset 1); write them only while the block is idle.
module flv_video_tag_deframer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  flvd_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output flvd_pkg::out_item_t                  out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [flvd_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic                in_valid_reg;
    flvd_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    flvd_pkg::out_item_t out_item_reg;
    flvd_pkg::cfg_t      cfg_reg;
    flvd_pkg::out_item_t result;
    logic                advance;
    logic                step;
    logic                cfg_write;

    // The result register frees up when empty or being taken this cycle.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Input register: load on every accepted item, drain when the parser steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    flvd_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Result register: hold while stalled, refill from the parser on each step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= result;
    end

    // Configuration port: zero wait states, word select on paddr bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.video_tag_kind  <= flvd_pkg::VIDEO_KIND_RESET;
            cfg_reg.jpeg_codec_code <= flvd_pkg::JPEG_CODEC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                flvd_pkg::REG_VIDEO_KIND: cfg_reg.video_tag_kind  <= pwdata[7:0];
                flvd_pkg::REG_JPEG_CODEC: cfg_reg.jpeg_codec_code <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            flvd_pkg::REG_VIDEO_KIND: prdata = {24'd0, cfg_reg.video_tag_kind};
            flvd_pkg::REG_JPEG_CODEC: prdata = {28'd0, cfg_reg.jpeg_codec_code};
            default:                  prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/flvd_checker.sv -----
// Port-level checks of the FLV video tag deframer, bound to the top level.
// Depends on flvd_pkg and flv_video_tag_deframer_defines.svh.
`include "flv_video_tag_deframer_defines.svh"

module flvd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input flvd_pkg::out_item_t out_item
);

    // Hold a stalled result unchanged.
    `FLVD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

    // Back-pressure on input only while a result is stuck.
    `FLVD_ASSERT_IMPLY(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

    // Body bytes carry no event.
    `FLVD_ASSERT_IMPLY(a_body_no_event, clk, rst_n, out_valid && out_item.payload_valid, out_item.event_code == flvd_pkg::EV_NONE)

    // Frame end without a body byte is only the empty-frame marker.
    `FLVD_ASSERT_IMPLY(a_empty_frame, clk, rst_n, out_valid && out_item.frame_last && !out_item.payload_valid, out_item.event_code == flvd_pkg::EV_TAG_OK)

endmodule

bind flv_video_tag_deframer flvd_checker u_flvd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ----- verif/flv_video_tag_deframer_tb.sv -----
// Self-checking testbench for the FLV video tag deframer: feeds byte streams,
// predicts every result item and compares them field by field.
// Depends on flvd_pkg and flv_video_tag_deframer.
`timescale 1ns / 1ps

module flv_video_tag_deframer_tb;

    localparam logic [3:0] HDR_LAST     = 4'(flvd_pkg::HDR_LEN - 1);
    localparam logic [3:0] TAG_LAST     = 4'(flvd_pkg::TAG_BYTES - 1);
    localparam logic [3:0] TRAILER_LAST = 4'(flvd_pkg::TRAILER_LEN - 1);
    localparam int         WHOLE_BODY   = 1 << 24;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    flvd_pkg::in_item_t            in_item;
    logic                          out_valid;
    logic                          out_ready;
    flvd_pkg::out_item_t           out_item;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [flvd_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    flv_video_tag_deframer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // Parser state mirrored by the predictor, plus its register copies.
    // ------------------------------------------------------------------
    flvd_pkg::phase_t cur_phase;
    logic [3:0]       pos_in_part;
    bit               hdr_ok_so_far;
    logic [31:0]      offset_shift;
    logic [7:0]       tag_kind;
    logic [23:0]      body_left;
    logic [63:0]      cur_ts;
    logic [7:0]       cfg_video_kind;
    logic [3:0]       cfg_jpeg_code;

    // Predicted results, oldest first.
    flvd_pkg::out_item_t deframed_q[$];

    int            bytes_fed;
    int            mismatches;
    int            n_hdr_ok;
    int            n_hdr_bad;
    int            n_tag_ok;
    int            n_tag_bad;
    int            n_body;

    // Idling controls shared by the sender and the receiver.
    bit            src_idle_on;
    bit            sink_idle_on;
    int            sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #6000000;
        $display("** flv_video_tag_deframer: FAILED **");
        $finish;
    end

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Drop back to header byte zero; registers are untouched.
    function automatic void enter_header();
        cur_phase     = flvd_pkg::PH_HEADER;
        pos_in_part   = 4'd0;
        hdr_ok_so_far = 1'b1;
    endfunction

    // Advance the mirrored parser by one byte and return the result it causes.
    function automatic flvd_pkg::out_item_t deframe_byte(input flvd_pkg::in_item_t it);
        flvd_pkg::out_item_t r;
        logic [7:0]          b;
        logic [3:0]          pos;
        bit                  tag_good;
        r = '0;
        b = it.stream_byte;
        if (it.restart)
            enter_header();
        pos = pos_in_part;
        case (cur_phase)
            flvd_pkg::PH_HEADER:
            begin
                case (pos)
                    4'd0: hdr_ok_so_far = (b == flvd_pkg::SIG_F);
                    4'd1: hdr_ok_so_far = hdr_ok_so_far & (b == flvd_pkg::SIG_L);
                    4'd2: hdr_ok_so_far = hdr_ok_so_far & (b == flvd_pkg::SIG_V);
                    4'd3: hdr_ok_so_far = hdr_ok_so_far & (b == flvd_pkg::FLV_VERSION);
                    4'd4: hdr_ok_so_far = hdr_ok_so_far & b[0];
                    4'd5, 4'd6, 4'd7, 4'd8:
                    begin
                        offset_shift = {offset_shift[23:0], b};
                        if (pos == 4'd8)
                            hdr_ok_so_far = hdr_ok_so_far
                                          & (offset_shift == flvd_pkg::DATA_OFFSET);
                    end
                    default: ;
                endcase
                if (pos >= HDR_LAST)
                begin
                    if (hdr_ok_so_far)
                    begin
                        r.event_code = flvd_pkg::EV_HDR_OK;
                        cur_phase    = flvd_pkg::PH_TAG;
                        pos_in_part  = 4'd0;
                        n_hdr_ok++;
                    end
                    else
                    begin
                        r.event_code = flvd_pkg::EV_HDR_BAD;
                        enter_header();
                        n_hdr_bad++;
                    end
                end
                else
                    pos_in_part = pos + 4'd1;
            end
            flvd_pkg::PH_TAG:
            begin
                if (pos == 4'd0)
                    tag_kind = b;
                else if (pos <= 4'd3)
                    body_left = {body_left[15:0], b};
                else if (pos < TAG_LAST)
                    cur_ts = {cur_ts[55:0], b};
                if (pos >= TAG_LAST)
                begin
                    tag_good = (tag_kind == cfg_video_kind) && (body_left != 24'd0) &&
                               (b[3:0] == cfg_jpeg_code);
                    if (!tag_good)
                    begin
                        r.event_code = flvd_pkg::EV_TAG_BAD;
                        enter_header();
                        n_tag_bad++;
                    end
                    else
                    begin
                        r.event_code      = flvd_pkg::EV_TAG_OK;
                        r.frame_timestamp = cur_ts;
                        body_left         = body_left - 24'd1;
                        pos_in_part       = 4'd0;
                        n_tag_ok++;
                        // A size of one means no body: flag the empty frame here.
                        if (body_left == 24'd0)
                        begin
                            r.frame_last = 1'b1;
                            cur_phase    = flvd_pkg::PH_TRAILER;
                        end
                        else
                            cur_phase = flvd_pkg::PH_BODY;
                    end
                end
                else
                    pos_in_part = pos + 4'd1;
            end
            flvd_pkg::PH_BODY:
            begin
                r.payload_byte    = b;
                r.payload_valid   = 1'b1;
                r.frame_timestamp = cur_ts;
                n_body++;
                if (body_left <= 24'd1)
                begin
                    body_left   = 24'd0;
                    r.frame_last = 1'b1;
                    cur_phase   = flvd_pkg::PH_TRAILER;
                    pos_in_part = 4'd0;
                end
                else
                    body_left = body_left - 24'd1;
            end
            default:
            begin
                // Trailer bytes are skipped.
                if (pos >= TRAILER_LAST)
                begin
                    cur_phase   = flvd_pkg::PH_TAG;
                    pos_in_part = 4'd0;
                end
                else
                    pos_in_part = pos + 4'd1;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one byte, hold it until accepted, then predict.
    // Valid stays high into the next item unless a gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input bit rs);
        flvd_pkg::in_item_t it;
        int                 gap;
        it.stream_byte = b;
        it.restart     = rs;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        deframed_q.push_back(deframe_byte(it));
        bytes_fed++;
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (deframed_q.size() != 0);
        // Leave margin before touching registers.
        repeat (4) @(posedge clk);
    endtask

    // Write one register, read it back, then update the predictor's copy.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] rd;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Read back at the same address.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == flvd_pkg::REG_VIDEO_KIND)
        begin
            cfg_video_kind = value[7:0];
            if (rd[7:0] !== value[7:0])
            begin
                mismatches++;
                $error("prdata video_tag_kind: expected %0h, got %0h", value[7:0], rd[7:0]);
            end
        end
        else
        begin
            cfg_jpeg_code = value[3:0];
            if (rd[3:0] !== value[3:0])
            begin
                mismatches++;
                $error("prdata jpeg_codec_code: expected %0h, got %0h", value[3:0], rd[3:0]);
            end
        end
    endtask

    // Stream header; bad_pos in 0..8 corrupts that byte, -1 keeps it well formed.
    task automatic send_header(input int bad_pos, input bit rs);
        logic [7:0] hb [0:12];
        hb[0] = flvd_pkg::SIG_F;
        hb[1] = flvd_pkg::SIG_L;
        hb[2] = flvd_pkg::SIG_V;
        hb[3] = flvd_pkg::FLV_VERSION;
        hb[4] = 8'($urandom) | 8'h01;
        hb[5] = flvd_pkg::DATA_OFFSET[31:24];
        hb[6] = flvd_pkg::DATA_OFFSET[23:16];
        hb[7] = flvd_pkg::DATA_OFFSET[15:8];
        hb[8] = flvd_pkg::DATA_OFFSET[7:0];
        for (int i = 9; i < flvd_pkg::HDR_LEN; i++)
            hb[i] = 8'($urandom);
        if (bad_pos == 4)
            hb[4][0] = 1'b0;
        else if (bad_pos >= 0 && bad_pos <= 8)
            hb[bad_pos] = hb[bad_pos] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < flvd_pkg::HDR_LEN; i++)
            send_item(hb[i], (i == 0) ? rs : 1'b0);
    endtask

    // One tag, then as much body as the parser asks for (up to body_cap) and
    // the trailer if the body ran to its end.
    task automatic send_frame(input logic [7:0] kind, input logic [23:0] size,
                              input logic [63:0] ts, input logic [7:0] codec,
                              input int body_cap);
        int n;
        send_item(kind, 1'b0);
        send_item(size[23:16], 1'b0);
        send_item(size[15:8], 1'b0);
        send_item(size[7:0], 1'b0);
        for (int i = 7; i >= 0; i--)
            send_item(ts[8*i +: 8], 1'b0);
        send_item(codec, 1'b0);
        if (cur_phase == flvd_pkg::PH_BODY)
        begin
            n = int'(size) - 1;
            if (n > body_cap)
                n = body_cap;
            for (int i = 0; i < n; i++)
                send_item(8'($urandom), 1'b0);
        end
        if (cur_phase == flvd_pkg::PH_TRAILER)
            for (int i = 0; i < flvd_pkg::TRAILER_LEN; i++)
                send_item(8'($urandom), 1'b0);
    endtask

    // A header and up to max_tags frames with random content; a few are broken.
    task automatic run_stream(input int max_tags);
        bit          rs;
        int          bad_pos;
        int          tags;
        int          r;
        int          cap;
        logic [7:0]  kind;
        logic [7:0]  codec;
        logic [23:0] sz;
        logic [63:0] ts;
        // Restart is needed unless the parser already waits at header byte zero.
        if (cur_phase != flvd_pkg::PH_HEADER || pos_in_part != 4'd0)
            rs = ($urandom_range(0, 9) != 0);
        else
            rs = ($urandom_range(0, 1) != 0);
        bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : -1;
        send_header(bad_pos, rs);
        tags = $urandom_range(1, max_tags);
        for (int t = 0; t < tags && cur_phase == flvd_pkg::PH_TAG; t++)
        begin
            kind = ($urandom_range(0, 9) != 0) ? cfg_video_kind : 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 8)
                sz = 24'd0;
            else if (r < 78)
                sz = 24'($urandom_range(1, 12));
            else if (r < 95)
                sz = 24'($urandom_range(13, 40));
            else
                sz = 24'($urandom);
            codec = 8'($urandom);
            if ($urandom_range(0, 9) != 0)
                codec[3:0] = cfg_jpeg_code;
            ts = {$urandom, $urandom};
            // Cut huge bodies short and now and then a normal one too.
            cap = (sz > 24'd40 || $urandom_range(0, 19) == 0) ? $urandom_range(0, 8) : WHOLE_BODY;
            send_frame(kind, sz, ts, codec, cap);
        end
    endtask

    // Random bytes with frequent restarts.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_header(-1, 1'b1);
        // Three body bytes, zero timestamp.
        send_frame(cfg_video_kind, 24'd4, 64'd0, 8'h01 | {4'h0, cfg_jpeg_code}, WHOLE_BODY);
        // Empty frame with an all-ones timestamp; upper codec nibble is ignored.
        send_frame(cfg_video_kind, 24'd1, '1, {4'hF, cfg_jpeg_code}, WHOLE_BODY);
        // Zero size rejects the tag.
        send_frame(cfg_video_kind, 24'd0, 64'h0123_4567_89AB_CDEF, {4'h0, cfg_jpeg_code},
                   WHOLE_BODY);
        send_header(-1, 1'b0);
        // Codec mismatch.
        send_frame(cfg_video_kind, 24'd3, 64'hFEDC_BA98_7654_3210, {4'h0, cfg_jpeg_code ^ 4'h1},
                   WHOLE_BODY);
        send_header(-1, 1'b0);
        // Not a video tag.
        send_frame(cfg_video_kind ^ 8'h01, 24'd3, 64'd5, {4'h0, cfg_jpeg_code}, WHOLE_BODY);
        // Each header field wrong in turn.
        for (int p = 0; p <= 8; p++)
            send_header(p, 1'b0);
        // Largest size, cut off after a few body bytes by a restart.
        send_header(-1, 1'b0);
        send_frame(cfg_video_kind, 24'hFF_FFFF, {$urandom, $urandom}, {4'h0, cfg_jpeg_code}, 6);
        send_header(-1, 1'b1);
        send_frame(cfg_video_kind, 24'd2, {$urandom, $urandom}, {4'h0, cfg_jpeg_code},
                   WHOLE_BODY);
        // Restart in the middle of a header.
        send_item(flvd_pkg::SIG_F, 1'b1);
        send_item(flvd_pkg::SIG_L, 1'b0);
        send_header(-1, 1'b1);
        send_frame(cfg_video_kind, 24'd5, {$urandom, $urandom}, {4'h0, cfg_jpeg_code},
                   WHOLE_BODY);
    endtask

    task automatic test_config();
        write_reg(flvd_pkg::REG_VIDEO_KIND, 32'd0);
        write_reg(flvd_pkg::REG_JPEG_CODEC, 32'd0);
        run_stream(4);
        run_stream(4);
        write_reg(flvd_pkg::REG_VIDEO_KIND, 32'd255);
        write_reg(flvd_pkg::REG_JPEG_CODEC, 32'd15);
        run_stream(4);
        run_stream(4);
        write_reg(flvd_pkg::REG_VIDEO_KIND, $urandom);
        write_reg(flvd_pkg::REG_JPEG_CODEC, $urandom);
        run_stream(4);
        run_stream(4);
    endtask

    // Three segments: idling on both sides, then none at the sender, then none
    // at the receiver; a fresh register setting for the later two.
    task automatic test_random();
        int stop_at;
        for (int seg = 0; seg < 3; seg++)
        begin
            if (seg > 0)
            begin
                write_reg(flvd_pkg::REG_VIDEO_KIND, $urandom_range(0, 255));
                write_reg(flvd_pkg::REG_JPEG_CODEC, $urandom_range(0, 15));
            end
            src_idle_on  = (seg != 1);
            sink_idle_on = (seg != 2);
            stop_at = bytes_fed + 30;
            while (bytes_fed < stop_at)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_noise();
                else
                    run_stream(6);
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // then the sender pauses until everything has drained.
    task automatic test_backpressure();
        int stop_at;
        src_idle_on = 1'b0;
        sink_hold   = 400;
        stop_at     = bytes_fed + 100;
        while (bytes_fed < stop_at)
            run_stream(3);
        settle();
        src_idle_on = 1'b1;
        stop_at     = bytes_fed + 40;
        while (bytes_fed < stop_at)
            run_stream(3);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off when requested.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 100)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        flvd_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (deframed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 100)
                    $error("unexpected result item: nothing pending");
            end
            else
            begin
                want = deframed_q.pop_front();
                check_field("payload_byte", 64'(want.payload_byte), 64'(out_item.payload_byte));
                check_field("payload_valid", 64'(want.payload_valid),
                            64'(out_item.payload_valid));
                check_field("frame_last", 64'(want.frame_last), 64'(out_item.frame_last));
                check_field("frame_timestamp", want.frame_timestamp, out_item.frame_timestamp);
                check_field("event_code", 64'(want.event_code), 64'(out_item.event_code));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        int waited;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        sink_hold    = 0;
        bytes_fed    = 0;
        mismatches   = 0;
        n_hdr_ok     = 0;
        n_hdr_bad    = 0;
        n_tag_ok     = 0;
        n_tag_bad    = 0;
        n_body       = 0;
        cfg_video_kind = flvd_pkg::VIDEO_KIND_RESET;
        cfg_jpeg_code  = flvd_pkg::JPEG_CODEC_RESET;
        enter_header();
        offset_shift = '0;
        tag_kind     = '0;
        body_left    = '0;
        cur_ts       = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config();
        test_random();
        test_backpressure();

        // Drain, then allow the pipeline latency to pass.
        in_valid <= 1'b0;
        waited = 0;
        while (deframed_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (deframed_q.size() != 0)
        begin
            mismatches++;
            $error("%0d predicted result items never came out", deframed_q.size());
        end

        $display("Run fed %0d stream bytes: %0d good and %0d bad headers, %0d frames taken,",
                 bytes_fed, n_hdr_ok, n_hdr_bad, n_tag_ok);
        $display("%0d tags rejected, %0d body bytes forwarded, under several register settings.",
                 n_tag_bad, n_body);
        if (mismatches == 0)
            $display("** flv_video_tag_deframer: PASSED **");
        else
            $display("** flv_video_tag_deframer: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/flvd_pkg.sv
hw/rtl/flvd_parser.sv
hw/rtl/flv_video_tag_deframer.sv
hw/rtl/flvd_checker.sv
verif/flv_video_tag_deframer_tb.sv
